// File: design/axis_deadzone_power_curve_macros.svh
// ---------------------------------------------------------------------------
// axis dead zone power curve assertion macros
// shared concurrent assertion forms, clocked on clk, disabled in rst
// ---------------------------------------------------------------------------
`ifndef AXIS_DEADZONE_POWER_CURVE_MACROS_SVH
`define AXIS_DEADZONE_POWER_CURVE_MACROS_SVH

// same-cycle implication
`define ADZPC_ASSERT_NOW(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// next-cycle implication
`define ADZPC_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

// File: design/adzpc_pkg.sv
// ---------------------------------------------------------------------------
// adzpc_pkg
// shared types and constants of the axis dead zone power curve
// ---------------------------------------------------------------------------
`default_nettype none

package adzpc_pkg;

  // register indexes of the config port
  localparam logic [1:0] CFG_DEAD_ZONE = 2'd0;
  localparam logic [1:0] CFG_CURVE_EXP = 2'd1;
  localparam logic [1:0] CFG_OUT_GAIN  = 2'd2;

  // flags that ride along with every word
  typedef struct packed {
    logic in_dz;  // sample fell inside the dead zone
    logic neg;    // result is negated
    logic one;    // power forced to one
    logic zero;   // power forced to zero
  } ctl_t;

  // round(2^30 * 2^-(2^-k)), k = 1..16
  localparam logic [29:0] EXP2_FRAC [16] = '{
    30'd759250125,  30'd902905651,  30'd984625594,  30'd1028218693,
    30'd1050733751, 30'd1062175491, 30'd1067942999, 30'd1070838486,
    30'd1072289173, 30'd1073015252, 30'd1073378477, 30'd1073560135,
    30'd1073650976, 30'd1073696399, 30'd1073719111, 30'd1073730468
  };

  localparam logic [30:0] R_ONE = 31'h4000_0000;

endpackage

`default_nettype wire

// File: design/adzpc_div_stage.sv
// ---------------------------------------------------------------------------
// adzpc_div_stage
// one restoring division step, one quotient bit per stage
// ---------------------------------------------------------------------------
`default_nettype none

module adzpc_div_stage #(
  parameter int DenW = 9
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              en,
  input  wire logic              v_in,
  input  wire adzpc_pkg::ctl_t   ctl_in,
  input  wire logic [DenW-1:0]   rem_in,
  input  wire logic [15:0]       q_in,
  input  wire logic [DenW-1:0]   den,
  output logic                   v_out,
  output adzpc_pkg::ctl_t        ctl_out,
  output logic [DenW-1:0]        rem_out,
  output logic [15:0]            q_out
);

  logic [DenW:0] t;
  logic [DenW:0] diff;
  logic          ge;

  assign t    = {rem_in, 1'b0};
  assign ge   = t >= {1'b0, den};
  assign diff = t - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      v_out <= 1'b0;
    end else if (en) begin
      v_out <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl_out <= ctl_in;
      rem_out <= ge ? diff[DenW-1:0] : t[DenW-1:0];
      q_out   <= {q_in[14:0], ge};
    end
  end

endmodule

`default_nettype wire

// File: design/adzpc_log_stage.sv
// ---------------------------------------------------------------------------
// adzpc_log_stage
// one squaring step of the log2 fraction, one fraction bit per stage
// ---------------------------------------------------------------------------
`default_nettype none

module adzpc_log_stage (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             en,
  input  wire logic             v_in,
  input  wire adzpc_pkg::ctl_t  ctl_in,
  input  wire logic [30:0]      m_in,
  input  wire logic [15:0]      frac_in,
  input  wire logic [3:0]       p_in,
  output logic                  v_out,
  output adzpc_pkg::ctl_t       ctl_out,
  output logic [30:0]           m_out,
  output logic [15:0]           frac_out,
  output logic [3:0]            p_out
);

  logic [61:0] sq;
  logic [31:0] s;

  assign sq = {31'b0, m_in} * {31'b0, m_in};
  assign s  = sq[61:30];

  always_ff @(posedge clk) begin
    if (rst) begin
      v_out <= 1'b0;
    end else if (en) begin
      v_out <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl_out  <= ctl_in;
      p_out    <= p_in;
      m_out    <= s[31] ? s[31:1] : s[30:0];
      frac_out <= {frac_in[14:0], s[31]};
    end
  end

endmodule

`default_nettype wire

// File: design/adzpc_exp_stage.sv
// ---------------------------------------------------------------------------
// adzpc_exp_stage
// one exp2 fraction step: multiply by a table entry when the bit is set
// ---------------------------------------------------------------------------
`default_nettype none

module adzpc_exp_stage (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             en,
  input  wire logic             v_in,
  input  wire adzpc_pkg::ctl_t  ctl_in,
  input  wire logic [30:0]      r_in,
  input  wire logic [15:0]      f_in,
  input  wire logic [4:0]       n_in,
  input  wire logic [29:0]      coef,
  output logic                  v_out,
  output adzpc_pkg::ctl_t       ctl_out,
  output logic [30:0]           r_out,
  output logic [15:0]           f_out,
  output logic [4:0]            n_out
);

  logic [60:0] prod;

  assign prod = {30'b0, r_in} * {31'b0, coef};

  always_ff @(posedge clk) begin
    if (rst) begin
      v_out <= 1'b0;
    end else if (en) begin
      v_out <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl_out <= ctl_in;
      n_out   <= n_in;
      f_out   <= {f_in[14:0], 1'b0};
      r_out   <= f_in[15] ? prod[60:30] : r_in;
    end
  end

endmodule

`default_nettype wire

// File: design/adzpc_out_buf.sv
// ---------------------------------------------------------------------------
// adzpc_out_buf
// two-entry output buffer, parts pipeline advance from downstream ready
// ---------------------------------------------------------------------------
`default_nettype none

`include "axis_deadzone_power_curve_macros.svh"

module adzpc_out_buf #(
  parameter int W = 27
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire logic [W-1:0]  din,
  output logic               room,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [W-1:0]       dout
);

  logic [W-1:0] mem [2];
  logic [1:0]   count;
  logic [1:0]   count_next;
  logic         wr_ptr;
  logic         rd_ptr;
  logic         pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = count != 2'd0;
  assign room      = count != 2'd2;
  assign dout      = mem[rd_ptr];

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + 2'd1;
    end else if (pop && !push) begin
      count_next = count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

  `ADZPC_ASSERT_NOW(a_count_range, 1'b1, count != 2'd3, "buffer count out of range")
  `ADZPC_ASSERT_NOW(a_no_push_full, push, count != 2'd2, "push into full buffer")
  `ADZPC_ASSERT_NEXT(a_pop_drains, pop && !push, count == $past(count) - 2'd1, "pop lost")

endmodule

`default_nettype wire

// File: design/axis_deadzone_power_curve.sv
// ---------------------------------------------------------------------------
// axis_deadzone_power_curve
// dead zone, normalize, power curve and gain on one signed axis sample
// ---------------------------------------------------------------------------
//
//   channel  signals                         direction  word
//   in       in_valid/in_ready, raw_sample   input      one signed sample
//   out      out_valid/out_ready,            output     shaped_value, in_dead_zone
//            shaped_value, in_dead_zone
//   cfg      cfg_we, cfg_index, cfg_data     input      register write, no handshake
//
// one word per cycle sustained while the output buffer has room
// the pipe holds 16 division steps, 16 log2 squarings and 16 exp2 multiplies
// rst is synchronous, clears valid bits and loads register defaults
// a stall at the output freezes the whole pipe once the two-entry output
// buffer is full; in_ready comes from a register, no combinational path
// ---------------------------------------------------------------------------
`default_nettype none

module axis_deadzone_power_curve #(
  parameter int FULL_SCALE = 350
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [15:0] raw_sample,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [25:0]      shaped_value,
  output logic             in_dead_zone,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  localparam int DenW = $clog2(FULL_SCALE + 1);
  localparam int NSt  = 16;

  // config registers
  logic [8:0]  dead_zone;
  logic [15:0] curve_exponent;
  logic [15:0] output_gain;

  always_ff @(posedge clk) begin
    if (rst) begin
      dead_zone      <= 9'd0;
      curve_exponent <= 16'd4096;
      output_gain    <= 16'd256;
    end else if (cfg_we) begin
      case (cfg_index)
        adzpc_pkg::CFG_DEAD_ZONE: dead_zone      <= cfg_data[8:0];
        adzpc_pkg::CFG_CURVE_EXP: curve_exponent <= cfg_data;
        adzpc_pkg::CFG_OUT_GAIN:  output_gain    <= cfg_data;
        default: ;
      endcase
    end
  end

  // pipe advance, held while output buffer is full
  logic en;
  logic room;
  assign en       = room;
  assign in_ready = en;

  // dead zone clamp and span
  logic [8:0]      dz_c;
  logic [DenW-1:0] den;
  assign dz_c = ({23'b0, dead_zone} >= 32'(FULL_SCALE)) ? 9'(FULL_SCALE - 1) : dead_zone;
  assign den  = DenW'(32'(FULL_SCALE) - {23'b0, dz_c});

  // stage 0: magnitude, dead zone test, numerator
  logic [16:0]      mag;
  logic             s0_v;
  adzpc_pkg::ctl_t  s0_ctl;
  logic [DenW-1:0]  s0_num;

  assign mag = raw_sample[15] ? (17'h10000 - {1'b0, raw_sample}) : {1'b0, raw_sample};

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_v <= 1'b0;
    end else if (en) begin
      s0_v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_ctl.in_dz <= mag < {8'b0, dz_c};
      // anything but a strictly positive sample is negated
      s0_ctl.neg   <= raw_sample[15] || (raw_sample == 16'd0);
      // magnitude at full scale clamps to one
      s0_ctl.one   <= mag >= 17'(FULL_SCALE);
      s0_ctl.zero  <= 1'b0;
      s0_num       <= DenW'(mag - {8'b0, dz_c});
    end
  end

  // division: norm = (num << 16) / den, one bit per stage
  logic             dv   [NSt+1];
  adzpc_pkg::ctl_t  dctl [NSt+1];
  logic [DenW-1:0]  drem [NSt+1];
  logic [15:0]      dq   [NSt+1];

  assign dv[0]   = s0_v;
  assign dctl[0] = s0_ctl;
  assign drem[0] = s0_num;
  assign dq[0]   = 16'd0;

  for (genvar i = 0; i < NSt; i++) begin : g_div
    adzpc_div_stage #(.DenW(DenW)) u_div (
      .clk(clk), .rst(rst), .en(en),
      .v_in(dv[i]), .ctl_in(dctl[i]), .rem_in(drem[i]), .q_in(dq[i]), .den(den),
      .v_out(dv[i+1]), .ctl_out(dctl[i+1]), .rem_out(drem[i+1]), .q_out(dq[i+1])
    );
  end

  // log2 entry: leading one and mantissa alignment
  logic [3:0]  lead;
  logic [30:0] xw;
  logic        l0_v;
  adzpc_pkg::ctl_t l0_ctl;
  adzpc_pkg::ctl_t l0_ctl_next;
  logic [30:0] l0_m;
  logic [3:0]  l0_p;

  always_comb begin
    lead = 4'd0;
    for (int i = 0; i < 16; i++) begin
      if (dq[NSt][i]) begin
        lead = 4'(i);
      end
    end
  end

  assign xw = {15'b0, dq[NSt]};

  // zero quotient forces the power to zero
  always_comb begin
    l0_ctl_next      = dctl[NSt];
    l0_ctl_next.zero = dq[NSt] == 16'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      l0_v <= 1'b0;
    end else if (en) begin
      l0_v <= dv[NSt];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      l0_ctl <= l0_ctl_next;
      l0_m   <= xw << (5'd30 - {1'b0, lead});
      l0_p   <= lead;
    end
  end

  // log2 fraction by repeated squaring
  logic             lv   [NSt+1];
  adzpc_pkg::ctl_t  lctl [NSt+1];
  logic [30:0]      lm   [NSt+1];
  logic [15:0]      lf   [NSt+1];
  logic [3:0]       lp   [NSt+1];

  assign lv[0]   = l0_v;
  assign lctl[0] = l0_ctl;
  assign lm[0]   = l0_m;
  assign lf[0]   = 16'd0;
  assign lp[0]   = l0_p;

  for (genvar i = 0; i < NSt; i++) begin : g_log
    adzpc_log_stage u_log (
      .clk(clk), .rst(rst), .en(en),
      .v_in(lv[i]), .ctl_in(lctl[i]), .m_in(lm[i]), .frac_in(lf[i]), .p_in(lp[i]),
      .v_out(lv[i+1]), .ctl_out(lctl[i+1]), .m_out(lm[i+1]), .frac_out(lf[i+1]),
      .p_out(lp[i+1])
    );
  end

  // scale -log2 by the exponent: P = (A * e) >> 12
  logic [20:0] neg_log;
  logic [36:0] scaled;
  logic [8:0]  p_int;
  logic        a_v;
  adzpc_pkg::ctl_t a_ctl;
  adzpc_pkg::ctl_t a_ctl_next;
  logic [15:0] a_f;
  logic [4:0]  a_n;

  assign neg_log = {5'(5'd16 - {1'b0, lp[NSt]}), 16'b0} - {5'b0, lf[NSt]};
  assign scaled  = {16'b0, neg_log} * {21'b0, curve_exponent};
  assign p_int   = scaled[36:28];

  // integer part past 16 underflows to zero
  always_comb begin
    a_ctl_next      = lctl[NSt];
    a_ctl_next.zero = lctl[NSt].zero || (p_int > 9'd16);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
    end else if (en) begin
      a_v <= lv[NSt];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_ctl <= a_ctl_next;
      a_f   <= scaled[27:12];
      a_n   <= p_int[4:0];
    end
  end

  // exp2 of the fraction, one table multiply per stage
  logic             ev   [NSt+1];
  adzpc_pkg::ctl_t  ectl [NSt+1];
  logic [30:0]      er   [NSt+1];
  logic [15:0]      ef   [NSt+1];
  logic [4:0]       en_n [NSt+1];

  assign ev[0]   = a_v;
  assign ectl[0] = a_ctl;
  assign er[0]   = adzpc_pkg::R_ONE;
  assign ef[0]   = a_f;
  assign en_n[0] = a_n;

  for (genvar i = 0; i < NSt; i++) begin : g_exp
    adzpc_exp_stage u_exp (
      .clk(clk), .rst(rst), .en(en),
      .v_in(ev[i]), .ctl_in(ectl[i]), .r_in(er[i]), .f_in(ef[i]), .n_in(en_n[i]),
      .coef(adzpc_pkg::EXP2_FRAC[i]),
      .v_out(ev[i+1]), .ctl_out(ectl[i+1]), .r_out(er[i+1]), .f_out(ef[i+1]),
      .n_out(en_n[i+1])
    );
  end

  // integer shift and special-case override
  logic [4:0]  sh;
  logic [30:0] r_sh;
  logic        w_v;
  adzpc_pkg::ctl_t w_ctl;
  logic [16:0] w_pow;

  assign sh   = 5'd14 + en_n[NSt];
  assign r_sh = er[NSt] >> sh;

  always_ff @(posedge clk) begin
    if (rst) begin
      w_v <= 1'b0;
    end else if (en) begin
      w_v <= ev[NSt];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      w_ctl <= ectl[NSt];
      if (ectl[NSt].one || (curve_exponent == 16'd0)) begin
        w_pow <= 17'h10000;
      end else if (ectl[NSt].zero) begin
        w_pow <= 17'd0;
      end else begin
        w_pow <= r_sh[16:0];
      end
    end
  end

  // gain multiply, Q16 by Q8.8
  logic [32:0] gprod;
  logic        g_v;
  adzpc_pkg::ctl_t g_ctl;
  logic [24:0] g_mag;

  assign gprod = {16'b0, w_pow} * {17'b0, output_gain};

  always_ff @(posedge clk) begin
    if (rst) begin
      g_v <= 1'b0;
    end else if (en) begin
      g_v <= w_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g_ctl <= w_ctl;
      g_mag <= gprod[32:8];
    end
  end

  // sign, dead zone result, into the output buffer
  logic [25:0] signed_val;
  logic [26:0] buf_din;
  logic [26:0] buf_dout;

  assign signed_val = g_ctl.neg ? (26'd0 - {1'b0, g_mag}) : {1'b0, g_mag};
  assign buf_din    = g_ctl.in_dz ? {26'd0, 1'b1} : {signed_val, 1'b0};

  adzpc_out_buf #(.W(27)) u_out (
    .clk(clk), .rst(rst),
    .push(en && g_v), .din(buf_din),
    .room(room),
    .out_valid(out_valid), .out_ready(out_ready), .dout(buf_dout)
  );

  assign shaped_value = buf_dout[26:1];
  assign in_dead_zone = buf_dout[0];

endmodule

`default_nettype wire
